// File: design/prvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prvr_pkg
// Shared types, constants and the arctangent table of the CORDIC vector unit.
// ----------------------------------------------------------------------------
package prvr_pkg;

   localparam int ITERATIONS_DEF = 16;
   localparam int TABLE_LEN      = 24;
   localparam int DATA_WIDTH     = 16;
   localparam int FRAC_BITS      = 12;
   localparam int WORK_W         = 32;
   localparam int DATA_LIMIT     = 2 ** (DATA_WIDTH - 1) - 1;

   // 1/K in Q30
   localparam logic signed [WORK_W-1:0] INV_GAIN_Q30 = 32'sd652032875;

   typedef enum logic [1:0] {
      CMD_POL2RECT = 2'd0,
      CMD_RECT2POL = 2'd1,
      CMD_ROTATE   = 2'd2,
      CMD_NONE     = 2'd3
   } prvr_cmd_type;

   typedef struct packed {
      prvr_cmd_type             cmd;
      logic                     zero_vec;
      logic signed [WORK_W-1:0] x;
      logic signed [WORK_W-1:0] y;
      logic [WORK_W-1:0]        z;
   } prvr_work_type;

   // atan(2^-i), 2^32 units per turn
   function automatic logic [WORK_W-1:0] prvr_atan(input int unsigned idx);
      logic [WORK_W-1:0] val;
      unique case (idx)
         0:  val = 32'h2000_0000;
         1:  val = 32'h12E4_051E;
         2:  val = 32'h09FB_385B;
         3:  val = 32'h0511_11D4;
         4:  val = 32'h028B_0D43;
         5:  val = 32'h0145_D7E1;
         6:  val = 32'h00A2_F61E;
         7:  val = 32'h0051_7C55;
         8:  val = 32'h0028_BE53;
         9:  val = 32'h0014_5F2F;
         10: val = 32'h000A_2F98;
         11: val = 32'h0005_17CC;
         12: val = 32'h0002_8BE6;
         13: val = 32'h0001_45F3;
         14: val = 32'h0000_A2F9;
         15: val = 32'h0000_517D;
         16: val = 32'h0000_28BE;
         17: val = 32'h0000_145F;
         18: val = 32'h0000_0A30;
         19: val = 32'h0000_0518;
         20: val = 32'h0000_028C;
         21: val = 32'h0000_0146;
         22: val = 32'h0000_00A3;
         23: val = 32'h0000_0051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: design/prvr_cordic_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prvr_cordic_stage
// One registered CORDIC micro-rotation with a fixed shift of STEP.
// ----------------------------------------------------------------------------
module prvr_cordic_stage #(
   parameter int STEP = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  prvr_pkg::prvr_work_type in_work,
   output logic                    out_valid,
   input  logic                    out_ready,
   output prvr_pkg::prvr_work_type out_work
);

   localparam logic [prvr_pkg::WORK_W-1:0] ATAN_STEP = prvr_pkg::prvr_atan(STEP);

   logic                    valid_ff;
   prvr_pkg::prvr_work_type work_ff;
   prvr_pkg::prvr_work_type work_in;
   logic signed [prvr_pkg::WORK_W-1:0] xs;
   logic signed [prvr_pkg::WORK_W-1:0] ys;
   logic                    ccw;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      xs = in_work.x >>> STEP;
      ys = in_work.y >>> STEP;
      // vectoring drives y to zero, rotation drives z to zero
      ccw = (in_work.cmd == prvr_pkg::CMD_RECT2POL) ? in_work.y[prvr_pkg::WORK_W-1]
                                                    : !in_work.z[prvr_pkg::WORK_W-1];
      work_in = in_work;
      if (ccw) begin
         work_in.x = in_work.x - ys;
         work_in.y = in_work.y + xs;
         work_in.z = in_work.z - ATAN_STEP;
      end else begin
         work_in.x = in_work.x + ys;
         work_in.y = in_work.y - xs;
         work_in.z = in_work.z + ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

// File: design/prvr_gain_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prvr_gain_round
// Gain compensation multiply, rounding, saturation and result register.
// ----------------------------------------------------------------------------
module prvr_gain_round (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  prvr_pkg::prvr_work_type in_work,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic signed [15:0]      x_out,
   output logic signed [15:0]      y_out,
   output logic [15:0]             mag_out,
   output logic signed [15:0]      angle_out
);

   localparam int PROD_W  = 2 * prvr_pkg::WORK_W;
   localparam int SHIFT   = 30 + prvr_pkg::FRAC_BITS;
   localparam int RES_W   = PROD_W - SHIFT;
   localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(64'sd1 <<< (SHIFT - 1));
   localparam logic signed [RES_W-1:0]  POS_LIM = RES_W'(prvr_pkg::DATA_LIMIT);
   localparam logic signed [RES_W-1:0]  NEG_LIM = -POS_LIM;
   localparam logic signed [RES_W-1:0]  MAG_MAX = RES_W'(65535);

   // product stage
   logic                       a_valid_ff;
   logic                       a_ready;
   logic signed [PROD_W-1:0]   prod_x_ff, prod_x_in;
   logic signed [PROD_W-1:0]   prod_y_ff, prod_y_in;
   prvr_pkg::prvr_cmd_type     a_cmd_ff;
   logic                       a_zero_ff;
   logic [15:0]                a_angle_ff;
   logic [prvr_pkg::WORK_W-1:0] z_rnd;

   // result stage
   logic                       b_valid_ff;
   logic                       b_ready;
   prvr_pkg::prvr_cmd_type     b_cmd_ff;
   logic signed [15:0]         x_out_ff, x_out_in;
   logic signed [15:0]         y_out_ff, y_out_in;
   logic [15:0]                mag_out_ff, mag_out_in;
   logic signed [15:0]         angle_out_ff, angle_out_in;
   logic signed [PROD_W-1:0]   sum_x, sum_y;
   logic signed [RES_W-1:0]    res_x, res_y;
   logic signed [15:0]         sat_x, sat_y;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign prod_x_in = in_work.x * prvr_pkg::INV_GAIN_Q30;
   assign prod_y_in = in_work.y * prvr_pkg::INV_GAIN_Q30;
   assign z_rnd     = in_work.z + 32'h0000_8000;

   always_comb begin
      sum_x = prod_x_ff + ROUND_BIAS;
      sum_y = prod_y_ff + ROUND_BIAS;
      res_x = sum_x[PROD_W-1:SHIFT];
      res_y = sum_y[PROD_W-1:SHIFT];

      if (res_x > POS_LIM) begin
         sat_x = POS_LIM[15:0];
      end else if (res_x < NEG_LIM) begin
         sat_x = NEG_LIM[15:0];
      end else begin
         sat_x = res_x[15:0];
      end
      if (res_y > POS_LIM) begin
         sat_y = POS_LIM[15:0];
      end else if (res_y < NEG_LIM) begin
         sat_y = NEG_LIM[15:0];
      end else begin
         sat_y = res_y[15:0];
      end

      x_out_in     = '0;
      y_out_in     = '0;
      mag_out_in   = '0;
      angle_out_in = '0;
      unique case (a_cmd_ff) inside
         prvr_pkg::CMD_POL2RECT, prvr_pkg::CMD_ROTATE: begin
            x_out_in = sat_x;
            y_out_in = sat_y;
         end
         prvr_pkg::CMD_RECT2POL: begin
            if (!a_zero_ff) begin
               if (res_x < 0) begin
                  mag_out_in = '0;
               end else if (res_x > MAG_MAX) begin
                  mag_out_in = MAG_MAX[15:0];
               end else begin
                  mag_out_in = res_x[15:0];
               end
               angle_out_in = a_angle_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= in_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
      if (a_ready && in_valid) begin
         prod_x_ff  <= prod_x_in;
         prod_y_ff  <= prod_y_in;
         a_cmd_ff   <= in_work.cmd;
         a_zero_ff  <= in_work.zero_vec;
         a_angle_ff <= z_rnd[prvr_pkg::WORK_W-1 -: 16];
      end
      if (b_ready && a_valid_ff) begin
         b_cmd_ff     <= a_cmd_ff;
         x_out_ff     <= x_out_in;
         y_out_ff     <= y_out_in;
         mag_out_ff   <= mag_out_in;
         angle_out_ff <= angle_out_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign x_out     = x_out_ff;
   assign y_out     = y_out_ff;
   assign mag_out   = mag_out_ff;
   assign angle_out = angle_out_ff;

   // unused command gives an all-zero result
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_cmd_ff == prvr_pkg::CMD_NONE
      |-> x_out_ff == 0 && y_out_ff == 0 && mag_out_ff == 0 && angle_out_ff == 0)
      else $error("unused command produced a nonzero result");

   // polar results never carry x or y
   a_polar_xy: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_cmd_ff == prvr_pkg::CMD_RECT2POL |-> x_out_ff == 0 && y_out_ff == 0)
      else $error("rect-to-polar result has x or y set");

   // rectangular results stay inside the symmetric range, no polar fields
   a_rect_sat: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && (b_cmd_ff == prvr_pkg::CMD_POL2RECT || b_cmd_ff == prvr_pkg::CMD_ROTATE)
      |-> x_out_ff != 16'sh8000 && y_out_ff != 16'sh8000
          && mag_out_ff == 0 && angle_out_ff == 0)
      else $error("rectangular result out of range or carries polar fields");

   // a stalled result stage keeps its request and the product stage keeps its own
   a_hold: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !out_ready && a_valid_ff |=> b_valid_ff && a_valid_ff)
      else $error("request dropped during stall");

endmodule

// File: design/polar_rect_vector_rotator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_rect_vector_rotator_unit
// Pipelined CORDIC: polar to rectangular, rectangular to polar, vector rotate.
// ----------------------------------------------------------------------------
//  channel  | ports                                           | dir
//  ---------+-------------------------------------------------+-----
//  request  | req_valid/ready, cmd, x_in, y_in, mag_in,       | in
//           | angle_in, adjust_in                             |
//  response | rsp_valid/ready, x_out, y_out, mag_out,         | out
//           | angle_out                                       |
//
//  One request per cycle sustained while rsp_ready accepts responses; stages in order: quadrant
//  fold, one stage per micro-rotation, gain multiply, round and saturate.
//  Reset clears only the stage valid bits.
//  Each stage holds while the next is full; empty stages fill under a stall,
//  so requests keep entering until the pipeline is full.
// ----------------------------------------------------------------------------
module polar_rect_vector_rotator_unit #(
   parameter int ITERATIONS = prvr_pkg::ITERATIONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic signed [15:0] req_x_in,
   input  logic signed [15:0] req_y_in,
   input  logic [14:0]        req_mag_in,
   input  logic signed [15:0] req_angle_in,
   input  logic signed [15:0] req_adjust_in,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_x_out,
   output logic signed [15:0] rsp_y_out,
   output logic [15:0]        rsp_mag_out,
   output logic signed [15:0] rsp_angle_out
);

   localparam int N_STEPS = (ITERATIONS > prvr_pkg::TABLE_LEN) ? prvr_pkg::TABLE_LEN
                                                                : ITERATIONS;
   localparam int W = prvr_pkg::WORK_W;

   logic                    s0_valid_ff;
   prvr_pkg::prvr_work_type s0_work_ff;
   prvr_pkg::prvr_work_type s0_work_in;
   logic signed [W-1:0]     ext_x, ext_y;

   logic                    chain_valid [0:N_STEPS];
   logic                    chain_ready [0:N_STEPS];
   prvr_pkg::prvr_work_type chain_work  [0:N_STEPS];

   assign req_ready = !s0_valid_ff || chain_ready[0];

   // quadrant fold into the CORDIC convergence range
   always_comb begin
      ext_x = $signed({{(W - 16 - prvr_pkg::FRAC_BITS){req_x_in[15]}}, req_x_in,
                       {prvr_pkg::FRAC_BITS{1'b0}}});
      ext_y = $signed({{(W - 16 - prvr_pkg::FRAC_BITS){req_y_in[15]}}, req_y_in,
                       {prvr_pkg::FRAC_BITS{1'b0}}});
      s0_work_in.cmd      = prvr_pkg::prvr_cmd_type'(req_cmd);
      s0_work_in.zero_vec = (req_x_in == '0) && (req_y_in == '0);
      s0_work_in.x        = '0;
      s0_work_in.y        = '0;
      s0_work_in.z        = '0;
      unique case (prvr_pkg::prvr_cmd_type'(req_cmd)) inside
         prvr_pkg::CMD_POL2RECT, prvr_pkg::CMD_ROTATE: begin
            if (req_cmd == prvr_pkg::CMD_POL2RECT) begin
               s0_work_in.x = $signed({{(W - 15 - prvr_pkg::FRAC_BITS){1'b0}}, req_mag_in,
                                       {prvr_pkg::FRAC_BITS{1'b0}}});
               s0_work_in.z = {req_angle_in, 16'b0};
            end else begin
               s0_work_in.x = ext_x;
               s0_work_in.y = ext_y;
               s0_work_in.z = {req_adjust_in, 16'b0};
            end
            // target outside [-90, +90): turn half way first
            if (s0_work_in.z[W-1] ^ s0_work_in.z[W-2]) begin
               s0_work_in.x      = -s0_work_in.x;
               s0_work_in.y      = -s0_work_in.y;
               s0_work_in.z[W-1] = ~s0_work_in.z[W-1];
            end
         end
         prvr_pkg::CMD_RECT2POL: begin
            if (req_x_in[15]) begin
               s0_work_in.x = -ext_x;
               s0_work_in.y = -ext_y;
               s0_work_in.z = {1'b1, {(W - 1){1'b0}}};
            end else begin
               s0_work_in.x = ext_x;
               s0_work_in.y = ext_y;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s0_valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         s0_work_ff <= s0_work_in;
      end
   end

   assign chain_valid[0] = s0_valid_ff;
   assign chain_work[0]  = s0_work_ff;

   for (genvar k = 0; k < N_STEPS; k++) begin : g_step
      prvr_cordic_stage #(
         .STEP (k)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_work   (chain_work[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_work  (chain_work[k+1])
      );
   end

   prvr_gain_round u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[N_STEPS]),
      .in_ready  (chain_ready[N_STEPS]),
      .in_work   (chain_work[N_STEPS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .x_out     (rsp_x_out),
      .y_out     (rsp_y_out),
      .mag_out   (rsp_mag_out),
      .angle_out (rsp_angle_out)
   );

endmodule
